>>> rtl/ial_pkg.sv
package ial_pkg;

   // Default geometry of the list store
   localparam int CAPACITY_DEFAULT    = 256;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Port field widths
   localparam int OPCODE_WIDTH   = 3;
   localparam int PORT_VAL_WIDTH = 32;
   localparam int POS_WIDTH      = 8;
   localparam int COUNT_WIDTH    = 9;
   localparam int STATUS_WIDTH   = 2;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_REMOVE = 3'd2,
      OP_FIND   = 3'd3,
      OP_READ   = 3'd4,
      OP_SWAP   = 3'd5
   } opcode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

endpackage

>>> rtl/indexed_array_list_top.sv
// Bounded ordered list of values held in one synchronous memory.
// Request channel (req_valid / req_stall): opcode, value, position and
// second_position. A request is taken when req_valid is high and req_stall
// is low; req_stall stays high while a request is being worked on.
// Response channel (rsp_valid / rsp_stall): read_value, found, entry_count
// and status, one response for every request, in request order.
// Append, removal of the last entry, find on an empty list, an unknown
// opcode and a refused request go from the check state to the response
// register; read, insert at the end and swap first pass through their own
// memory access states. Insert at position p < n (n = entry count) makes
// one memory move per cycle, remove at p < n - 1 shifts the entries above
// p down, and find compares one entry per cycle. Each shifted entry costs
// one read and one write of the single port pair, each searched entry one
// read. The next request is taken in the cycle after a response is loaded,
// so no new request is taken before the last one's response is loaded.
// While the receiver holds rsp_stall high the response stays stable; the next
// request is still taken and worked on until its response must be loaded.
// Reset (synchronous, active high) empties the list and drops any pending
// response; the memory contents are not cleared.
module indexed_array_list_top #(
   parameter int CAPACITY    = ial_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = ial_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ial_pkg::OPCODE_WIDTH-1:0]   req_opcode,
   input  logic [ial_pkg::PORT_VAL_WIDTH-1:0] req_value,
   input  logic [ial_pkg::POS_WIDTH-1:0]      req_position,
   input  logic [ial_pkg::POS_WIDTH-1:0]      req_second_position,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ial_pkg::PORT_VAL_WIDTH-1:0] rsp_read_value,
   output logic                               rsp_found,
   output logic [ial_pkg::COUNT_WIDTH-1:0]    rsp_entry_count,
   output logic [ial_pkg::STATUS_WIDTH-1:0]   rsp_status
);
   import ial_pkg::*;

   // Address and count widths follow from the capacity
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   // Comparison width wide enough for both a position and a count
   localparam int PW = (CW > POS_WIDTH) ? CW : POS_WIDTH;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_FLUSH,
      S_INS_WR,
      S_RD_CAP,
      S_SWAP_B,
      S_SWAP_C,
      S_SWAP_D,
      S_RESP
   } state_type;

   state_type                  state_ff;
   logic [OPCODE_WIDTH-1:0]    op_ff;
   logic [VALUE_WIDTH-1:0]     val_ff;
   logic [POS_WIDTH-1:0]       pos_ff;
   logic [POS_WIDTH-1:0]       pos2_ff;
   logic [CW-1:0]              count_ff;
   logic [AW-1:0]              cur_ff;
   logic [AW-1:0]              end_ff;
   logic                       pend_ff;
   logic [AW-1:0]              pend_idx_ff;
   logic                       found_ff;
   logic [VALUE_WIDTH-1:0]     rdval_ff;
   status_type                 status_ff;
   logic [VALUE_WIDTH-1:0]     hold_ff;

   logic                       rsp_valid_ff;
   logic [PORT_VAL_WIDTH-1:0]  rsp_read_value_ff;
   logic                       rsp_found_ff;
   logic [COUNT_WIDTH-1:0]     rsp_entry_count_ff;
   logic [STATUS_WIDTH-1:0]    rsp_status_ff;

   // Entry memory: one write port, one registered read port
   logic [VALUE_WIDTH-1:0]     mem [CAPACITY];
   logic [VALUE_WIDTH-1:0]     mem_rdata_ff;
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic [VALUE_WIDTH-1:0]     mem_wdata;
   logic [AW-1:0]              mem_raddr;

   logic                       req_take;
   logic                       rsp_free;
   logic                       full;
   logic                       ins_ok;
   logic                       pos_ok;
   logic                       pos2_ok;
   logic [PW-1:0]              pos_cmp;
   logic [PW-1:0]              pos2_cmp;
   logic [PW-1:0]              count_cmp;
   logic [AW-1:0]              pos_addr;
   logic [AW-1:0]              pos2_addr;
   logic [AW-1:0]              count_addr;
   logic                       scan_busy;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   // Response register can take a new response this cycle
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Range checks against the current count
   assign pos_cmp    = PW'(pos_ff);
   assign pos2_cmp   = PW'(pos2_ff);
   assign count_cmp  = PW'(count_ff);
   assign full       = (count_ff == CW'(CAPACITY));
   assign ins_ok     = (pos_cmp <= count_cmp);
   assign pos_ok     = (pos_cmp < count_cmp);
   assign pos2_ok    = (pos2_cmp < count_cmp);
   assign pos_addr   = AW'(pos_ff);
   assign pos2_addr  = AW'(pos2_ff);
   assign count_addr = AW'(count_ff);
   assign scan_busy  = (state_ff == S_SCAN) || (state_ff == S_FLUSH);

   // Memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pos_addr;
      mem_wdata = val_ff;
      mem_raddr = pos_addr;
      case (state_ff)
         S_CHECK: begin
            // append writes at the tail; the read of position serves read and swap
            if (op_ff == OP_APPEND && !full) begin
               mem_we    = 1'b1;
               mem_waddr = count_addr;
            end
         end
         S_SCAN: begin
            mem_raddr = cur_ff;
         end
         S_INS_WR: begin
            mem_we = 1'b1;
         end
         S_SWAP_B: begin
            mem_raddr = pos2_addr;
         end
         S_SWAP_C: begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata_ff;
         end
         S_SWAP_D: begin
            mem_we    = 1'b1;
            mem_waddr = pos2_addr;
            mem_wdata = hold_ff;
         end
         default: begin
         end
      endcase
      // Move the entry read last cycle one place up (insert) or down (remove)
      if (scan_busy && pend_ff) begin
         if (op_ff == OP_INSERT) begin
            mem_we    = 1'b1;
            mem_waddr = pend_idx_ff + AW'(1);
            mem_wdata = mem_rdata_ff;
         end else if (op_ff == OP_REMOVE) begin
            mem_we    = 1'b1;
            mem_waddr = pend_idx_ff - AW'(1);
            mem_wdata = mem_rdata_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   // Sequencer, list count and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop a taken response unless a new one is loaded in its place
         if (rsp_valid_ff && !rsp_stall && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end

         // Compare the entry read last cycle during a find
         if (scan_busy && pend_ff && op_ff == OP_FIND && mem_rdata_ff == val_ff) begin
            found_ff <= 1'b1;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  op_ff     <= req_opcode;
                  val_ff    <= VALUE_WIDTH'(req_value);
                  pos_ff    <= req_position;
                  pos2_ff   <= req_second_position;
                  found_ff  <= 1'b0;
                  rdval_ff  <= '0;
                  status_ff <= ST_OK;
                  pend_ff   <= 1'b0;
                  state_ff  <= S_CHECK;
               end
            end
            S_CHECK: begin
               state_ff <= S_RESP;
               case (op_ff)
                  OP_APPEND: begin
                     if (full) begin
                        status_ff <= ST_FULL;
                     end else begin
                        count_ff <= count_ff + CW'(1);
                     end
                  end
                  OP_INSERT: begin
                     if (full) begin
                        status_ff <= ST_FULL;
                     end else if (!ins_ok) begin
                        status_ff <= ST_RANGE;
                     end else if (pos_cmp == count_cmp) begin
                        state_ff <= S_INS_WR;
                     end else begin
                        // walk down from the last entry to position
                        cur_ff   <= AW'(count_ff - CW'(1));
                        end_ff   <= pos_addr;
                        state_ff <= S_SCAN;
                     end
                  end
                  OP_REMOVE: begin
                     if (!pos_ok) begin
                        status_ff <= ST_RANGE;
                     end else if (pos_cmp + PW'(1) == count_cmp) begin
                        count_ff <= count_ff - CW'(1);
                     end else begin
                        // walk up from the entry above position to the last one
                        cur_ff   <= pos_addr + AW'(1);
                        end_ff   <= AW'(count_ff - CW'(1));
                        state_ff <= S_SCAN;
                     end
                  end
                  OP_FIND: begin
                     if (count_ff != '0) begin
                        cur_ff   <= '0;
                        end_ff   <= AW'(count_ff - CW'(1));
                        state_ff <= S_SCAN;
                     end
                  end
                  OP_READ: begin
                     if (!pos_ok) begin
                        status_ff <= ST_RANGE;
                     end else begin
                        state_ff <= S_RD_CAP;
                     end
                  end
                  OP_SWAP: begin
                     if (!pos_ok || !pos2_ok) begin
                        status_ff <= ST_RANGE;
                     end else begin
                        state_ff <= S_SWAP_B;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            S_SCAN: begin
               // one read issued per cycle; advance the cursor toward the end mark
               pend_ff     <= 1'b1;
               pend_idx_ff <= cur_ff;
               if (cur_ff == end_ff) begin
                  state_ff <= S_FLUSH;
               end else if (op_ff == OP_INSERT) begin
                  cur_ff <= cur_ff - AW'(1);
               end else begin
                  cur_ff <= cur_ff + AW'(1);
               end
            end
            S_FLUSH: begin
               // last read is consumed this cycle
               pend_ff <= 1'b0;
               if (op_ff == OP_INSERT) begin
                  state_ff <= S_INS_WR;
               end else begin
                  if (op_ff == OP_REMOVE) begin
                     count_ff <= count_ff - CW'(1);
                  end
                  state_ff <= S_RESP;
               end
            end
            S_INS_WR: begin
               count_ff <= count_ff + CW'(1);
               state_ff <= S_RESP;
            end
            S_RD_CAP: begin
               rdval_ff <= mem_rdata_ff;
               state_ff <= S_RESP;
            end
            S_SWAP_B: begin
               // entry at the first position arrives now; hold it
               hold_ff  <= mem_rdata_ff;
               state_ff <= S_SWAP_C;
            end
            S_SWAP_C: begin
               state_ff <= S_SWAP_D;
            end
            S_SWAP_D: begin
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (rsp_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_read_value_ff  <= PORT_VAL_WIDTH'(rdval_ff);
                  rsp_found_ff       <= found_ff;
                  rsp_entry_count_ff <= COUNT_WIDTH'(count_ff);
                  rsp_status_ff      <= status_ff;
                  state_ff           <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

>>> tb/sv/indexed_array_list_checker.sv
`timescale 1ns / 100ps

module indexed_array_list_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [ial_pkg::OPCODE_WIDTH-1:0]   req_opcode,
   input  logic [ial_pkg::PORT_VAL_WIDTH-1:0] req_value,
   input  logic [ial_pkg::POS_WIDTH-1:0]      req_position,
   input  logic [ial_pkg::POS_WIDTH-1:0]      req_second_position,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [ial_pkg::PORT_VAL_WIDTH-1:0] rsp_read_value,
   input  logic                               rsp_found,
   input  logic [ial_pkg::COUNT_WIDTH-1:0]    rsp_entry_count,
   input  logic [ial_pkg::STATUS_WIDTH-1:0]   rsp_status,
   output int                                 mismatch_count,
   output int                                 waiting_count,
   output int                                 list_depth
);
   import ial_pkg::*;

   localparam int LIST_CAPACITY = CAPACITY_DEFAULT;

   typedef struct {
      logic [PORT_VAL_WIDTH-1:0] read_value;
      logic                      found;
      logic [COUNT_WIDTH-1:0]    entry_count;
      status_type                status;
   } list_response_type;

   logic [PORT_VAL_WIDTH-1:0] list_entries [LIST_CAPACITY];
   int                        list_len;
   int                        failures;
   list_response_type         pending_responses [$];

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= 10) $display("%0t checker: %s", $realtime, msg);
   endtask

   // Apply one request to the shadow list and return the response it owes.
   function automatic list_response_type predict_list_op(
      input logic [OPCODE_WIDTH-1:0]   op,
      input logic [PORT_VAL_WIDTH-1:0] val,
      input logic [POS_WIDTH-1:0]      pos,
      input logic [POS_WIDTH-1:0]      pos2
   );
      list_response_type         r;
      logic [PORT_VAL_WIDTH-1:0] held;
      int                        i;
      r.read_value = '0;
      r.found      = 1'b0;
      r.status     = ST_OK;
      case (op)
         OP_APPEND: begin
            if (list_len >= LIST_CAPACITY) r.status = ST_FULL;
            else begin
               list_entries[list_len] = val;
               list_len++;
            end
         end
         OP_INSERT: begin
            if (list_len >= LIST_CAPACITY) r.status = ST_FULL;
            else if (int'(pos) > list_len) r.status = ST_RANGE;
            else begin
               for (i = list_len; i > int'(pos); i--) list_entries[i] = list_entries[i-1];
               list_entries[pos] = val;
               list_len++;
            end
         end
         OP_REMOVE: begin
            if (int'(pos) >= list_len) r.status = ST_RANGE;
            else begin
               for (i = pos; i + 1 < list_len; i++) list_entries[i] = list_entries[i+1];
               list_len--;
            end
         end
         OP_FIND: begin
            for (i = 0; i < list_len; i++)
               if (list_entries[i] == val) r.found = 1'b1;
         end
         OP_READ: begin
            if (int'(pos) >= list_len) r.status = ST_RANGE;
            else r.read_value = list_entries[pos];
         end
         OP_SWAP: begin
            if (int'(pos) >= list_len || int'(pos2) >= list_len) r.status = ST_RANGE;
            else begin
               held               = list_entries[pos];
               list_entries[pos]  = list_entries[pos2];
               list_entries[pos2] = held;
            end
         end
         default: ;
      endcase
      r.entry_count = COUNT_WIDTH'(list_len);
      return r;
   endfunction

   always @(posedge clock) begin
      list_response_type want;
      if (reset) begin
         list_len = 0;
         pending_responses.delete();
      end else begin
         // Responses come first: one accepted at this edge belongs to an older request.
         if (rsp_valid && !rsp_stall) begin
            if (pending_responses.size() == 0) begin
               note_failure($sformatf("response with none outstanding: %h %b %0d %0d",
                  rsp_read_value, rsp_found, rsp_entry_count, rsp_status));
            end else begin
               want = pending_responses.pop_front();
               if (rsp_read_value !== want.read_value || rsp_found !== want.found ||
                   rsp_entry_count !== want.entry_count || rsp_status !== want.status)
                  note_failure($sformatf(
                     "expected read %h found %b count %0d status %0d, got %h %b %0d %0d",
                     want.read_value, want.found, want.entry_count, want.status,
                     rsp_read_value, rsp_found, rsp_entry_count, rsp_status));
            end
         end
         if (req_valid && !req_stall)
            pending_responses.push_back(predict_list_op(req_opcode, req_value,
               req_position, req_second_position));
      end
      mismatch_count <= failures;
      waiting_count  <= pending_responses.size();
      list_depth     <= list_len;
   end

endmodule

>>> tb/sv/indexed_array_list_top_tb.sv
`timescale 1ns / 100ps

module indexed_array_list_top_tb;
   import ial_pkg::*;

   // Opcodes the block does not decode; they must come back as no-ops.
   localparam logic [OPCODE_WIDTH-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OPCODE_WIDTH-1:0] OP_SPARE_HI = 3'd7;

   // Stimulus shaping: grow the list, shrink it, or churn around a level.
   localparam int MODE_MIXED  = 0;
   localparam int MODE_GROW   = 1;
   localparam int MODE_SHRINK = 2;

   localparam int LIST_CAPACITY    = CAPACITY_DEFAULT;
   localparam int WATCHDOG_LIMIT   = 5000;   // well above hold-off + one full shift
   localparam int SETTLE_CYCLES    = 300;    // longer than the longest request, a full-length shift or find
   localparam int LONG_HOLD_START  = 1500;
   localparam int LONG_HOLD_CYCLES = 400;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [OPCODE_WIDTH-1:0]   req_opcode = '0;
   logic [PORT_VAL_WIDTH-1:0] req_value = '0;
   logic [POS_WIDTH-1:0]      req_position = '0;
   logic [POS_WIDTH-1:0]      req_second_position = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [PORT_VAL_WIDTH-1:0] rsp_read_value;
   logic                      rsp_found;
   logic [COUNT_WIDTH-1:0]    rsp_entry_count;
   logic [STATUS_WIDTH-1:0]   rsp_status;

   int mismatch_count;
   int waiting_count;
   int list_depth;
   int cycle_no = 0;
   int quiet_cycles = 0;
   int burst_left = 0;

   logic [PORT_VAL_WIDTH-1:0] sent_values [$];

   indexed_array_list_top uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_value           (req_value),
      .req_position        (req_position),
      .req_second_position (req_second_position),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_read_value      (rsp_read_value),
      .rsp_found           (rsp_found),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_status          (rsp_status)
   );

   indexed_array_list_checker list_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_value           (req_value),
      .req_position        (req_position),
      .req_second_position (req_second_position),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_read_value      (rsp_read_value),
      .rsp_found           (rsp_found),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_status          (rsp_status),
      .mismatch_count      (mismatch_count),
      .waiting_count       (waiting_count),
      .list_depth          (list_depth)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) cycle_no <= cycle_no + 1;

   // Watchdog: count edges where neither channel moves a request or response.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int idle_span();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // Pick a position, mostly inside the list (end slot allowed for insert),
   // sometimes past the end to hit the range check.
   function automatic logic [POS_WIDTH-1:0] pick_position(input int depth, input bit end_ok);
      int last_ok;
      last_ok = depth - 1 + (end_ok ? 1 : 0);
      if (last_ok > 255) last_ok = 255;
      if (last_ok >= 0 && $urandom_range(99) < 88) return POS_WIDTH'($urandom_range(last_ok, 0));
      if (last_ok >= 255) return POS_WIDTH'($urandom_range(255, 0));
      return POS_WIDTH'($urandom_range(255, last_ok + 1));
   endfunction

   // Reuse values already stored often enough that find hits as well as misses.
   function automatic logic [PORT_VAL_WIDTH-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 30 && sent_values.size() > 0)
         return sent_values[$urandom_range(sent_values.size() - 1, 0)];
      if (r < 36) return '0;
      if (r < 42) return '1;
      return $urandom();
   endfunction

   // Offer one request and hold it until accepted, then idle for a random gap, which may be none.
   task automatic offer_request(
      input logic [OPCODE_WIDTH-1:0]   op,
      input logic [PORT_VAL_WIDTH-1:0] val,
      input logic [POS_WIDTH-1:0]      pos,
      input logic [POS_WIDTH-1:0]      pos2
   );
      int gap;
      req_valid           <= 1'b1;
      req_opcode          <= op;
      req_value           <= val;
      req_position        <= pos;
      req_second_position <= pos2;
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         gap = idle_span();
         if ($urandom_range(99) < 3) burst_left = 20;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait for every outstanding response.
   task automatic drain_outstanding();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (waiting_count == 0);
      @(posedge clock);
   endtask

   task automatic random_request(input int mode);
      int                        r;
      logic [OPCODE_WIDTH-1:0]   op;
      logic [PORT_VAL_WIDTH-1:0] val;
      r = $urandom_range(99);
      if ($urandom_range(99) < 50) op = OP_SPARE_LO;
      else op = OP_SPARE_HI;
      case (mode)
         MODE_GROW: begin
            if (r < 45) op = OP_APPEND;
            else if (r < 80) op = OP_INSERT;
            else if (r < 85) op = OP_FIND;
            else if (r < 90) op = OP_READ;
            else if (r < 95) op = OP_SWAP;
            else if (r < 97) op = OP_REMOVE;
         end
         MODE_SHRINK: begin
            if (r < 80) op = OP_REMOVE;
            else if (r < 85) op = OP_FIND;
            else if (r < 90) op = OP_READ;
            else if (r < 95) op = OP_SWAP;
            else if (r < 97) op = OP_APPEND;
            else if (r < 98) op = OP_INSERT;
         end
         default: begin
            if (r < 20) op = OP_APPEND;
            else if (r < 35) op = OP_INSERT;
            else if (r < 60) op = OP_REMOVE;
            else if (r < 75) op = OP_FIND;
            else if (r < 85) op = OP_READ;
            else if (r < 97) op = OP_SWAP;
         end
      endcase
      val = pick_value();
      if (op == OP_APPEND || op == OP_INSERT) begin
         sent_values.push_back(val);
         if (sent_values.size() > 64) void'(sent_values.pop_front());
      end
      offer_request(op, val, pick_position(list_depth, op == OP_INSERT),
         pick_position(list_depth, 1'b0));
   endtask

   // Response side: random stalls, runs with none, and one long hold-off
   // so the block backs up and stalls its request side.
   initial begin
      int  n;
      int  calm_left;
      bit  held_long;
      held_long = 1'b0;
      calm_left = 0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (!held_long && cycle_no >= LONG_HOLD_START) begin
            held_long = 1'b1;
            n = LONG_HOLD_CYCLES;
         end else if (calm_left > 0) begin
            calm_left--;
            n = 0;
         end else begin
            n = idle_span();
            if ($urandom_range(99) < 4) calm_left = 30;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat (1 + ($urandom_range(99) < 70 ? 0 : $urandom_range(4, 1))) @(posedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty list: every position is out of range, find misses.
      offer_request(OP_READ,   32'h0000_0000, 8'd0,   8'd0);
      offer_request(OP_REMOVE, 32'h0000_0000, 8'd0,   8'd0);
      offer_request(OP_FIND,   32'h0000_0000, 8'd0,   8'd0);
      offer_request(OP_SWAP,   32'h0000_0000, 8'd0,   8'd0);
      offer_request(OP_INSERT, 32'h1111_1111, 8'd1,   8'd0);
      // Build a short list: insert at the front, append, insert at the end and inside.
      offer_request(OP_INSERT, 32'hFFFF_FFFF, 8'd0,   8'd0);
      offer_request(OP_APPEND, 32'h0000_0000, 8'd255, 8'd255);
      offer_request(OP_APPEND, 32'hA5A5_5A5A, 8'd0,   8'd0);
      offer_request(OP_INSERT, 32'h1234_5678, 8'd3,   8'd0);
      offer_request(OP_INSERT, 32'h8000_0001, 8'd1,   8'd0);
      // Reads at both ends and just past them.
      offer_request(OP_READ,   32'h0000_0000, 8'd0,   8'd0);
      offer_request(OP_READ,   32'h0000_0000, 8'd4,   8'd0);
      offer_request(OP_READ,   32'h0000_0000, 8'd5,   8'd0);
      offer_request(OP_READ,   32'hFFFF_FFFF, 8'd255, 8'd255);
      // Find a hit at the front, one at the back and a miss.
      offer_request(OP_FIND,   32'hFFFF_FFFF, 8'd0,   8'd0);
      offer_request(OP_FIND,   32'h1234_5678, 8'd0,   8'd0);
      offer_request(OP_FIND,   32'hDEAD_BEEF, 8'd0,   8'd0);
      // Swap the ends, a slot with itself, and with a slot past the end.
      offer_request(OP_SWAP,   32'h0000_0000, 8'd0,   8'd4);
      offer_request(OP_SWAP,   32'h0000_0000, 8'd2,   8'd2);
      offer_request(OP_SWAP,   32'h0000_0000, 8'd1,   8'd255);
      // Remove the last entry, the first, and a position past the end.
      offer_request(OP_REMOVE, 32'h0000_0000, 8'd4,   8'd0);
      offer_request(OP_REMOVE, 32'h0000_0000, 8'd0,   8'd0);
      offer_request(OP_REMOVE, 32'h0000_0000, 8'd5,   8'd0);
      // Undecoded opcodes with every field bit set.
      offer_request(OP_SPARE_LO, 32'hFFFF_FFFF, 8'd255, 8'd255);
      offer_request(OP_SPARE_HI, 32'hFFFF_FFFF, 8'd255, 8'd255);
      drain_outstanding();

      // Churn around a small fill level.
      repeat (60) begin
         if (list_depth < 6) random_request(MODE_GROW);
         else if (list_depth > 24) random_request(MODE_SHRINK);
         else random_request(MODE_MIXED);
      end
      // Fill to capacity, then keep pushing so full is refused repeatedly.
      while (list_depth < LIST_CAPACITY) random_request(MODE_GROW);
      drain_outstanding();
      repeat (30) random_request(MODE_GROW);
      // Drain back down with long shifts, then churn a little more.
      while (list_depth > 128) random_request(MODE_SHRINK);
      repeat (40) random_request(MODE_MIXED);

      drain_outstanding();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
